@@ rtl/core/tccs_pkg.sv @@
// tccs_pkg: field widths, opcodes and shared types of the text console
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package tccs_pkg;

    // field widths of one command beat and one response beat
    localparam int OP_W   = 3;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = ATTR_W + CHAR_W;

    // opcodes
    localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
    localparam logic [OP_W-1:0] OP_NL    = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
    localparam logic [OP_W-1:0] OP_READ  = 3'd3;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd4;

    // enables and write data toward the screen memory
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [CELL_W-1:0] wr_data;
    } t_mem_ctl;

endpackage

`default_nettype wire

@@ rtl/core/tccs_if.sv @@
// tccs_cmd_if / tccs_rsp_if: valid-ready channels of the text console
// depends on tccs_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tccs_cmd_if;
    import tccs_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attribute;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;

    modport source (output valid, opcode, char_code, attribute, column, row, input ready);
    modport sink   (input valid, opcode, char_code, attribute, column, row, output ready);
endinterface

interface tccs_rsp_if;
    import tccs_pkg::*;
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_word;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;

    modport source (output valid, cell_word, cursor_column, cursor_row, input ready);
    modport sink   (input valid, cell_word, cursor_column, cursor_row, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tccs_mem.sv @@
// tccs_mem: screen cell memory, one write and one registered read per cycle
// depends on tccs_pkg
`timescale 1ns / 1ps
`default_nettype none

module tccs_mem #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire                       i_clk,
    input  wire tccs_pkg::t_mem_ctl   i_ctl,
    input  wire [AW-1:0]              i_wr_addr,
    input  wire [AW-1:0]              i_rd_addr,
    output logic [tccs_pkg::CELL_W-1:0] o_rd_data
);
    import tccs_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_ctl.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/text_console_cursor_scroll.sv @@
// text_console_cursor_scroll: text screen with cursor, scroll and clear
// depends on tccs_pkg, tccs_if (tccs_cmd_if, tccs_rsp_if) and tccs_mem
//
//  channel | dir | beat contents
//  i_cmd   | in  | opcode, char_code, attribute, column, row
//  o_rsp   | out | cell_word, cursor_column, cursor_row
//
// put char, positioned write, unused opcodes: response registered on accept;
// cell read: response after the read wait state; newline or wrap on the bottom
// row: the single memory write port moves one cell a cycle, then zeroes the last row
// clear: one cell zeroed per cycle
// after reset a clearing pass runs with i_cmd.ready low
// a new command is taken while the previous response is being taken
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_scroll #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tccs_cmd_if.sink   i_cmd,
    tccs_rsp_if.source o_rsp
);
    import tccs_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int MOVE   = COLUMNS * (ROWS - 1);
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RDWAIT = 2'd1;
    localparam logic [1:0] ST_SCROLL = 2'd2;
    localparam logic [1:0] ST_FILL   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic              r_wb_valid, n_wb_valid;
    logic [ADDR_W-1:0] r_wb_addr, n_wb_addr;
    logic              r_pend, n_pend;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_out_valid, n_out_valid;
    logic [CELL_W-1:0] r_out_word, n_out_word;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;

    logic              accept;
    logic              pos_ok;
    logic [ADDR_W-1:0] pos_addr, cur_addr;
    logic              wrap, at_bottom, do_nl;
    logic [COL_W-1:0]  acc_col;
    logic [ROW_W-1:0]  acc_row;
    t_mem_ctl          mem_ctl;
    logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
    logic [CELL_W-1:0] mem_rd_data;

    // handshake
    assign i_cmd.ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_cmd.valid && i_cmd.ready;

    // address of the requested position and of the cursor
    assign pos_ok   = (i_cmd.column < COL_W'(COLUMNS)) && (i_cmd.row < ROW_W'(ROWS));
    assign pos_addr = ADDR_W'(i_cmd.row) * ADDR_W'(COLUMNS) + ADDR_W'(i_cmd.column);
    assign cur_addr = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);

    // cursor after the accepted command
    assign wrap      = (r_col == COL_W'(COLUMNS - 1));
    assign at_bottom = (r_row == ROW_W'(ROWS - 1));
    assign do_nl     = (i_cmd.opcode == OP_NL) || ((i_cmd.opcode == OP_PUT) && wrap);

    always_comb begin
        acc_col = r_col;
        acc_row = r_row;
        if (do_nl) begin
            acc_col = '0;
            acc_row = at_bottom ? r_row : r_row + ROW_W'(1);
        end else if (i_cmd.opcode == OP_PUT) begin
            acc_col = r_col + COL_W'(1);
        end else if (i_cmd.opcode == OP_CLEAR) begin
            acc_col = '0;
            acc_row = '0;
        end
    end

    // memory port selection: scroll writeback, zero fill, then command
    always_comb begin
        mem_ctl     = '0;
        mem_wr_addr = pos_addr;
        mem_rd_addr = pos_addr;
        if (r_wb_valid) begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_data = mem_rd_data;
            mem_wr_addr     = r_wb_addr;
        end else if (r_state == ST_FILL) begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = r_ptr;
        end else if (accept && (i_cmd.opcode == OP_PUT)) begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_data = {i_cmd.attribute, i_cmd.char_code};
            mem_wr_addr     = cur_addr;
        end else if (accept && (i_cmd.opcode == OP_WRITE) && pos_ok) begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_data = {i_cmd.attribute, i_cmd.char_code};
        end
        if (r_state == ST_SCROLL) begin
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = r_ptr + ADDR_W'(COLUMNS);
        end else if (accept && (i_cmd.opcode == OP_READ) && pos_ok) begin
            mem_ctl.rd_en = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_wb_valid  = 1'b0;
        n_wb_addr   = r_wb_addr;
        n_pend      = r_pend;
        n_col       = r_col;
        n_row       = r_row;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_word  = r_out_word;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_col = acc_col;
                    n_row = acc_row;
                    if (do_nl && at_bottom) begin
                        n_state = ST_SCROLL;
                        n_ptr   = '0;
                        n_pend  = 1'b1;
                    end else if (i_cmd.opcode == OP_CLEAR) begin
                        n_state = ST_FILL;
                        n_ptr   = '0;
                        n_pend  = 1'b1;
                    end else if ((i_cmd.opcode == OP_READ) && pos_ok) begin
                        n_state = ST_RDWAIT;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_word  = '0;
                        n_out_col   = acc_col;
                        n_out_row   = acc_row;
                    end
                end
            end
            ST_RDWAIT: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                n_out_word  = mem_rd_data;
                n_out_col   = r_col;
                n_out_row   = r_row;
            end
            ST_SCROLL: begin
                n_wb_valid = 1'b1;
                n_wb_addr  = r_ptr;
                n_ptr      = r_ptr + ADDR_W'(1);
                if (r_ptr == ADDR_W'(MOVE - 1)) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                if (!r_wb_valid) begin
                    n_ptr = r_ptr + ADDR_W'(1);
                    if (r_ptr == ADDR_W'(CELLS - 1)) begin
                        n_state = ST_IDLE;
                        n_pend  = 1'b0;
                        if (r_pend) begin
                            n_out_valid = 1'b1;
                            n_out_word  = '0;
                            n_out_col   = r_col;
                            n_out_row   = r_row;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_ptr       <= '0;
            r_wb_valid  <= 1'b0;
            r_pend      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_wb_valid  <= n_wb_valid;
            r_pend      <= n_pend;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wb_addr  <= n_wb_addr;
        r_out_word <= n_out_word;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
    end

    tccs_mem #(
        .DEPTH (CELLS),
        .AW    (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (mem_wr_addr),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // response beat
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.cell_word     = r_out_word;
    assign o_rsp.cursor_column = r_out_col;
    assign o_rsp.cursor_row    = r_out_row;

    // checks
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ready |-> (r_state == ST_IDLE))
        else $error("command taken outside idle");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < COL_W'(COLUMNS)) && (r_row < ROW_W'(ROWS)))
        else $error("cursor out of screen");

    a_wb_from_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL) |=> r_wb_valid)
        else $error("scroll read without writeback");

    a_busy_no_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCROLL) || (r_state == ST_RDWAIT)) |-> !r_out_valid)
        else $error("response pending while busy");

endmodule

`default_nettype wire
